@@ rtl/postfix_stack_evaluator_assert.svh @@
// Assertion macros for the postfix stack evaluator
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pse_pkg.sv @@
// Types, codes and defaults shared by the postfix stack evaluator
`timescale 1ns / 1ps
package pse_pkg;

  localparam int VAL_W           = 32;
  localparam int MODE_W          = 3;
  localparam int STATUS_W        = 3;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4,
    MODE_END  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_OP  = 3'd1,
    ST_FEW     = 3'd2,
    ST_DIV0    = 3'd3,
    ST_NOT_ONE = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_READ   = 3'd2,
    S_EXEC   = 3'd3,
    S_RESP   = 3'd4
  } pse_state_e;

  typedef enum logic [2:0] {
    AP_IDLE = 3'd0,
    AP_MUL  = 3'd1,
    AP_RND  = 3'd2,
    AP_DSET = 3'd3,
    AP_DIV  = 3'd4,
    AP_SAT  = 3'd5
  } alu_phase_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
    logic             sat;
  } alu_rsp_t;

endpackage

@@ rtl/pse_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pse_alu.sv @@
// Multi-cycle Q-format arithmetic unit: saturating add, subtract, multiply, divide
`timescale 1ns / 1ps
module pse_alu import pse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int NUM_W = VAL_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int MAG_W = 2 * VAL_W;
  localparam logic [MAG_W-1:0] HALF = (MAG_W'(1) << FRAC_BITS) >> 1;
  localparam logic [MAG_W-1:0] POS_MAX = MAG_W'(32'h7FFF_FFFF);
  localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(32'h8000_0000);

  alu_phase_e       phase_q, phase_d;
  logic [VAL_W-1:0] ma_q, ma_d;
  logic [VAL_W-1:0] mb_q, mb_d;
  logic             neg_q, neg_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic [NUM_W-1:0] dq_q, dq_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [VAL_W:0]   sum;
  logic [VAL_W:0]   sum_abs;
  logic [VAL_W:0]   rem_sh;
  logic             ge;
  logic [VAL_W:0]   rem_sub;
  logic [NUM_W-1:0] dq_step;

  assign sum = (req_i.op == ALU_SUB)
             ? {req_i.left[VAL_W-1], req_i.left} - {req_i.right[VAL_W-1], req_i.right}
             : {req_i.left[VAL_W-1], req_i.left} + {req_i.right[VAL_W-1], req_i.right};
  assign sum_abs = sum[VAL_W] ? (VAL_W+1)'(-sum) : sum;

  assign rem_sh  = {rem_q, dq_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, mb_q};
  assign rem_sub = rem_sh - {1'b0, mb_q};
  assign dq_step = {dq_q[NUM_W-2:0], ge};

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      AP_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            ALU_ADD, ALU_SUB: phase_d = AP_SAT;
            ALU_MUL:          phase_d = AP_MUL;
            ALU_DIV:          phase_d = AP_DSET;
            default:          phase_d = AP_IDLE;
          endcase
        end
      end
      AP_MUL:  phase_d = AP_RND;
      AP_RND:  phase_d = AP_SAT;
      AP_DSET: phase_d = AP_DIV;
      AP_DIV:  phase_d = (cnt_q == '0) ? AP_SAT : AP_DIV;
      AP_SAT:  phase_d = AP_IDLE;
      default: phase_d = AP_IDLE;
    endcase
  end

  always_comb begin
    ma_d  = ma_q;
    mb_d  = mb_q;
    neg_d = neg_q;
    mag_d = mag_q;
    dq_d  = dq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    rsp_o = '0;
    unique case (phase_q)
      AP_IDLE: begin
        if (req_i.start) begin
          ma_d = req_i.left[VAL_W-1]  ? VAL_W'(-req_i.left)  : req_i.left;
          mb_d = req_i.right[VAL_W-1] ? VAL_W'(-req_i.right) : req_i.right;
          if (req_i.op == ALU_ADD || req_i.op == ALU_SUB) begin
            neg_d = sum[VAL_W];
            mag_d = MAG_W'(sum_abs);
          end else begin
            neg_d = req_i.left[VAL_W-1] ^ req_i.right[VAL_W-1];
          end
        end
      end
      AP_MUL: mag_d = MAG_W'(ma_q) * MAG_W'(mb_q);
      AP_RND: mag_d = (mag_q + HALF) >> FRAC_BITS;
      AP_DSET: begin
        dq_d  = (NUM_W'(ma_q) << FRAC_BITS) + NUM_W'(mb_q >> 1);
        rem_d = '0;
        cnt_d = CNT_W'(NUM_W - 1);
      end
      AP_DIV: begin
        dq_d  = dq_step;
        rem_d = ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          mag_d = MAG_W'(dq_step);
        end
      end
      AP_SAT: begin
        rsp_o.done = 1'b1;
        if (!neg_q) begin
          rsp_o.sat   = mag_q > POS_MAX;
          rsp_o.value = rsp_o.sat ? POS_MAX[VAL_W-1:0] : mag_q[VAL_W-1:0];
        end else begin
          rsp_o.sat   = mag_q > NEG_MAX;
          rsp_o.value = rsp_o.sat ? NEG_MAX[VAL_W-1:0] : VAL_W'(-mag_q[VAL_W-1:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= AP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

endmodule

@@ rtl/postfix_stack_evaluator.sv @@
// Top level of the postfix stack evaluator: sequencer, stack RAM and arithmetic unit
//
// Channel  Role    Handshake                 Payload
// in       sink    in_valid_i / in_stall_o   mode_i, operand_value_i
// out      source  out_valid_o / out_stall_i status_o, top_value_o, stack_level_o,
//                                            is_final_o, saturated_o
//
// Push, end, bad and rejected tokens skip the arithmetic unit; add, subtract,
// multiply and divide use it, divide by way of its one-bit-per-cycle divider.
// The top of stack sits in a register; the rest lives in a one-port-read RAM,
// so an operator reads its left operand from the RAM in the S_READ state.
// Reset empties the stack and clears the error; RAM contents are not cleared.
// A token is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
module postfix_stack_evaluator import pse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [MODE_W-1:0]                mode_i,
  input  logic signed [VAL_W-1:0]          operand_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [STATUS_W-1:0]              status_o,
  output logic signed [VAL_W-1:0]          top_value_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] stack_level_o,
  output logic                             is_final_o,
  output logic                             saturated_o
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  pse_state_e       state_q, state_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [VAL_W-1:0] opv_q, opv_d;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          err_q, err_d;
  logic [VAL_W-1:0] top_q, top_d;
  logic             sat_q, sat_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VAL_W-1:0]    topv_q, topv_d;
  logic [CNT_W-1:0]    level_q, level_d;
  logic                final_q, final_d;
  logic                osat_q, osat_d;

  logic              ram_we;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [VAL_W-1:0]  ram_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  alu_op_e           alu_op;
  logic              is_alu_mode;
  logic              go_alu;
  logic              out_free;
  logic              is_end;

  assign cnt_m1      = count_q - CNT_W'(1);
  assign cnt_m2      = count_q - CNT_W'(2);
  assign is_end      = mode_q == MODE_END;
  assign is_alu_mode = (mode_q >= MODE_ADD) && (mode_q <= MODE_DIV);
  assign go_alu      = !is_end && err_q == ST_OK && is_alu_mode && count_q >= CNT_W'(2)
                    && !(mode_q == MODE_DIV && top_q == '0);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;

  always_comb begin
    unique case (mode_q)
      MODE_ADD: alu_op = ALU_ADD;
      MODE_SUB: alu_op = ALU_SUB;
      MODE_MUL: alu_op = ALU_MUL;
      default:  alu_op = ALU_DIV;
    endcase
  end

  pse_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_m1[ADDR_W-1:0]),
    .wdata_i(top_q),
    .raddr_i(cnt_m2[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  pse_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: state_d = go_alu ? S_READ : S_RESP;
      S_READ:   state_d = S_EXEC;
      S_EXEC:   if (alu_rsp.done) state_d = S_RESP;
      S_RESP:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mode_d        = mode_q;
    opv_d         = opv_q;
    count_d       = count_q;
    err_d         = err_q;
    top_d         = top_q;
    sat_d         = sat_q;
    ram_we        = 1'b0;
    alu_req       = '0;
    alu_req.op    = alu_op;
    alu_req.left  = ram_rdata;
    alu_req.right = top_q;
    status_d      = status_q;
    topv_d        = topv_q;
    level_d       = level_q;
    final_d       = final_q;
    osat_d        = osat_q;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_i;
          opv_d  = operand_value_i;
        end
      end
      S_DECODE: begin
        sat_d = 1'b0;
        if (!is_end && err_q == ST_OK) begin
          priority if (mode_q == MODE_PUSH) begin
            if (count_q >= CNT_W'(STACK_DEPTH)) begin
              err_d = ST_FULL;
            end else begin
              ram_we  = count_q != '0;
              top_d   = opv_q;
              count_d = count_q + CNT_W'(1);
            end
          end else if (!is_alu_mode) begin
            err_d = ST_BAD_OP;
          end else if (count_q < CNT_W'(2)) begin
            err_d = ST_FEW;
          end else if (mode_q == MODE_DIV && top_q == '0) begin
            err_d = ST_DIV0;
          end else begin
            err_d = ST_OK;
          end
        end
      end
      S_READ: alu_req.start = 1'b1;
      S_EXEC: begin
        if (alu_rsp.done) begin
          top_d   = alu_rsp.value;
          sat_d   = alu_rsp.sat;
          count_d = cnt_m1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          final_d     = is_end;
          osat_d      = sat_q;
          if (is_end) begin
            priority if (err_q != ST_OK) begin
              status_d = err_q;
              topv_d   = '0;
            end else if (count_q != CNT_W'(1)) begin
              status_d = ST_NOT_ONE;
              topv_d   = '0;
            end else begin
              status_d = ST_OK;
              topv_d   = top_q;
            end
            level_d = '0;
            count_d = '0;
            err_d   = ST_OK;
          end else begin
            status_d = err_q;
            topv_d   = (count_q != '0) ? top_q : '0;
            level_d  = count_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    opv_q    <= opv_d;
    top_q    <= top_d;
    sat_q    <= sat_d;
    status_q <= status_d;
    topv_q   <= topv_d;
    level_q  <= level_d;
    final_q  <= final_d;
    osat_q   <= osat_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign top_value_o   = topv_q;
  assign stack_level_o = level_q;
  assign is_final_o    = final_q;
  assign saturated_o   = osat_q;

`include "postfix_stack_evaluator_assert.svh"

  `PSE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `PSE_ASSERT_NOW(a_final_empty, out_valid_o && is_final_o, stack_level_o == '0, "end leaves values")
  `PSE_ASSERT_NOW(a_sat_ok, out_valid_o && saturated_o, status_o == ST_OK && !is_final_o, "sat with error")
  `PSE_ASSERT_NOW(a_alu_in_exec, alu_rsp.done, state_q == S_EXEC, "arith result outside exec")
  `PSE_ASSERT_NEXT(a_accept_decode, in_valid_i && !in_stall_o, state_q == S_DECODE, "transfer lost")

endmodule
